/* hw/rtl/cdi_pkg.sv */
// Package for the calendar day incrementer: item structs, limits and month lengths.
// No dependencies; every other file in hw/rtl imports it.
package cdi_pkg;

  localparam int unsigned MonthsInYear = 12;
  localparam logic [3:0]  MonthJan     = 4'd1;
  localparam logic [3:0]  MonthFeb     = 4'd2;
  localparam logic [5:0]  DayTop       = 6'd63;
  localparam logic [5:0]  DayFirst     = 6'd1;
  localparam logic signed [15:0] YearTop = 16'sh7FFF;

  // Offset that makes every 16-bit year positive while keeping it modulo 400.
  localparam logic [16:0] LeapOffset   = 17'd40000;
  // Reciprocal of 100 scaled by 2^24, rounded up; exact for values below 2^17.
  localparam logic [17:0] Recip100     = 18'd167773;
  localparam int unsigned Recip100Shift = 24;

  localparam logic [2:0] WeekdayNone   = 3'd0;
  localparam logic [2:0] WeekdayMonday = 3'd1;
  localparam logic [2:0] WeekdaySunday = 3'd7;

  typedef struct packed {
    logic              has_year;
    logic signed [15:0] year_value;
    logic              has_month;
    logic [3:0]        month_value;
    logic [5:0]        day_value;
    logic              has_weekday;
    logic [2:0]        weekday;
  } cdi_in_t;

  typedef struct packed {
    logic signed [15:0] year_out;
    logic [3:0]        month_out;
    logic [5:0]        day_out;
    logic [2:0]        weekday_out;
    logic              saturated;
  } cdi_out_t;

  // Month lengths with February at 29; unknown month codes count as 31 days.
  function automatic logic [4:0] month_len_base(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:    len = 5'd29;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/cdi_month_days.sv */
// Length of a month, with the Gregorian leap year rule applied to February when a nonzero year is given.
// Depends on cdi_pkg.
module cdi_month_days
  import cdi_pkg::*;
(
  input  logic              has_year,
  input  logic signed [15:0] year_value,
  input  logic [3:0]        month_value,
  output logic [4:0]        days
);

  logic [16:0] year_pos;
  logic [34:0] prod;
  logic [10:0] quot100;
  logic [16:0] back100;
  logic        div4;
  logic        div100;
  logic        div400;
  logic        leap;

  // The offset year stays positive, so the century test is an exact
  // reciprocal multiply followed by a check that the quotient maps back.
  assign year_pos = {year_value[15], year_value} + LeapOffset;
  assign prod     = 35'(year_pos) * 35'(Recip100);
  assign quot100  = prod[Recip100Shift +: 11];
  assign back100  = {quot100, 6'b0} + {1'b0, quot100, 5'b0} + {4'b0, quot100, 2'b0};
  assign div4     = (year_pos[1:0] == 2'b00);
  assign div100   = (back100 == year_pos);
  assign div400   = div100 && (quot100[1:0] == 2'b00);
  assign leap     = div4 && (!div100 || div400);

  always_comb begin
    days = month_len_base(month_value);
    if (has_year && (year_value != 16'sd0) && (month_value == MonthFeb) && !leap) begin
      days = 5'd28;
    end
  end

endmodule

/* hw/rtl/cdi_next_day.sv */
// Next-day arithmetic for one registered item: weekday, day, month and year roll.
// Depends on cdi_pkg and cdi_month_days.
module cdi_next_day
  import cdi_pkg::*;
(
  input  cdi_in_t  item,
  output cdi_out_t result
);

  logic [4:0] days;

  cdi_month_days u_month_days (
    .has_year    (item.has_year),
    .year_value  (item.year_value),
    .month_value (item.month_value),
    .days        (days)
  );

  always_comb begin
    result.year_out  = item.year_value;
    result.month_out = item.month_value;
    result.day_out   = item.day_value;
    result.saturated = 1'b0;

    // Weekday advances Monday through Sunday and wraps; a zero code stays zero.
    if (!item.has_weekday) begin
      result.weekday_out = WeekdayNone;
    end else if (item.weekday == WeekdaySunday) begin
      result.weekday_out = WeekdayMonday;
    end else if (item.weekday == WeekdayNone) begin
      result.weekday_out = WeekdayNone;
    end else begin
      result.weekday_out = item.weekday + 3'd1;
    end

    if (item.has_month) begin
      if (item.day_value < {1'b0, days}) begin
        result.day_out = item.day_value + 6'd1;
      end else if (32'(item.month_value) < MonthsInYear) begin
        result.month_out = item.month_value + 4'd1;
        result.day_out   = DayFirst;
      end else if (item.has_year) begin
        if (item.year_value == YearTop) begin
          result.saturated = 1'b1;
        end else begin
          result.year_out  = item.year_value + 16'sd1;
          result.month_out = MonthJan;
          result.day_out   = DayFirst;
        end
      end
    end else begin
      if (item.day_value == DayTop) begin
        result.saturated = 1'b1;
      end else begin
        result.day_out = item.day_value + 6'd1;
      end
    end
  end

endmodule

/* hw/rtl/calendar_day_incrementer.sv */
// Top level of the calendar day incrementer: input register, next-day logic, result register.
// Depends on cdi_pkg and cdi_next_day.
//
//   Channel   Handshake              Payload     Direction
//   --------  ---------------------  ----------  ---------
//   input     start high, busy low   date        in
//   result    done high, one cycle   next_date   out
//
// An item is taken at every clock edge where start is high; busy is never raised,
// so the block sustains one item per cycle. Each item passes through the input
// register and then the result register on its way to next_date, and done is
// high for a single cycle as it arrives there. The receiver cannot stall,
// so no item is ever held back. The synchronous reset clears the two valid flags.
module calendar_day_incrementer
  import cdi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cdi_in_t  date,
  output logic     done,
  output cdi_out_t next_date
);

  logic     in_valid;
  cdi_in_t  in_item;
  cdi_out_t result_next;

  // Nothing inside can back up, so the input side is always open.
  assign busy = 1'b0;

  // The input register only holds the item; the result register drives the outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
    if (start && !busy) begin
      in_item <= date;
    end
    if (in_valid) begin
      next_date <= result_next;
    end
  end

  // All of the calendar arithmetic sits between the two registers.
  cdi_next_day u_next_day (
    .item   (in_item),
    .result (result_next)
  );

endmodule
